### hw/rtl/tbah_pkg.sv
// ----------------------------------------------------------------------------
// Time bucket average history package
// Shared types and constants for the bucketed averaging datapath.
// ----------------------------------------------------------------------------
package tbah_pkg;

  localparam logic [31:0] BUCKET_SECONDS_RESET = 32'd21600;

  typedef struct packed {
    logic        [31:0] start;
    logic signed [15:0] sample;
  } word_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EVAL,
    B_DIV,
    B_CLOSE,
    B_ADD
  } back_state_t;

endpackage

### hw/rtl/tbah_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbah_div #(
  parameter int N = 32,
  parameter int D = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [N-1:0] quotient,
  output logic [D-1:0] remainder
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  quo;
  logic [N-1:0]  quo_next;
  logic [D-1:0]  rem;
  logic [D-1:0]  rem_next;
  logic [D-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic [D:0]    shifted;
  logic [D:0]    diff;

  always_comb begin
    shifted = {rem, quo[N-1]};
    diff    = shifted - {1'b0, dsr};
    if (!diff[D]) begin
      rem_next = diff[D-1:0];
      quo_next = {quo[N-2:0], 1'b1};
    end else begin
      rem_next = shifted[D-1:0];
      quo_next = {quo[N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### hw/rtl/tbah_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accept input words, floor the time to the bucket length, pass on a word.
// ----------------------------------------------------------------------------
module tbah_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [31:0]         cfg_data,
  input  logic                push,
  output logic                full,
  input  logic [31:0]         time_seconds,
  input  logic signed [15:0]  sample_value,
  output logic                q_push,
  output tbah_pkg::word_t     q_word,
  input  logic                q_full
);

  tbah_pkg::front_state_t state;
  tbah_pkg::front_state_t state_next;

  logic [31:0]        bucket_seconds;
  logic [31:0]        bucket_len;
  logic [31:0]        time_q;
  logic signed [15:0] sample_q;
  logic               accept;
  logic               div_busy;
  logic               div_done;
  logic [31:0]        div_quo;
  logic [31:0]        div_rem;

  assign bucket_len = (bucket_seconds == '0) ? 32'd1 : bucket_seconds;
  assign accept     = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_seconds <= tbah_pkg::BUCKET_SECONDS_RESET;
    end else if (cfg_write) begin
      bucket_seconds <= cfg_data;
    end
  end

  tbah_div #(
    .N(32),
    .D(32)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (time_seconds),
    .divisor   (bucket_len),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbah_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      time_q   <= time_seconds;
      sample_q <= sample_value;
    end
  end

  always_comb begin
    state_next    = state;
    full          = 1'b1;
    q_push        = 1'b0;
    q_word.start  = time_q - div_rem;
    q_word.sample = sample_q;
    unique case (state)
      tbah_pkg::F_IDLE: begin
        full = 1'b0;
        if (push) begin
          state_next = tbah_pkg::F_DIV;
        end
      end
      tbah_pkg::F_DIV: begin
        if (div_done && !div_busy && (div_quo == div_quo)) begin
          state_next = tbah_pkg::F_PUSH;
        end
      end
      tbah_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = tbah_pkg::F_IDLE;
        end
      end
      default: state_next = tbah_pkg::F_IDLE;
    endcase
  end

endmodule

### hw/rtl/tbah_queue.sv
// ----------------------------------------------------------------------------
// Word queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tbah_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tbah_pkg::word_t word_in,
  output logic            full,
  input  logic            pop,
  output tbah_pkg::word_t word_out,
  output logic            empty
);

  tbah_pkg::word_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign word_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= word_in;
    end
  end

endmodule

### hw/rtl/tbah_back.sv
// ----------------------------------------------------------------------------
// Back end
// Close buckets, compute rounded means, keep the history ring and the sums.
// ----------------------------------------------------------------------------
module tbah_back #(
  parameter int HISTORY_DEPTH = 64,
  parameter int MAX_COUNT     = 65535
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  tbah_pkg::word_t    q_word,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic               bucket_closed,
  output logic signed [15:0] closed_average,
  output logic signed [15:0] evicted_value,
  output logic [15:0]        bucket_count
);

  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);

  tbah_pkg::back_state_t state;
  tbah_pkg::back_state_t state_next;

  logic signed [15:0] mem [HISTORY_DEPTH];
  logic signed [15:0] rd_data;
  logic [HW-1:0]      head;
  logic [FW-1:0]      fill;

  logic [31:0]        bucket_start;
  logic signed [31:0] sample_sum;
  logic [15:0]        sample_count;
  logic [15:0]        count_after;

  logic [31:0]        w_start;
  logic signed [15:0] w_sample;
  logic               close;
  logic               closed_r;
  logic               neg;
  logic signed [15:0] avg_r;
  logic signed [15:0] evict_r;
  logic signed [15:0] avg;
  logic [31:0]        mag;
  logic               out_valid;
  logic               slot_free;

  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [32:0]        div_quo;
  logic [16:0]        div_rem;

  assign close       = (bucket_start == '0) || (bucket_start != w_start);
  assign mag         = sample_sum[31] ? (~sample_sum + 32'sd1) : sample_sum;
  assign count_after = (sample_count < 16'(MAX_COUNT)) ? sample_count + 16'd1 : sample_count;
  assign avg         = (sample_count == '0) ? 16'sd0 :
                       (neg ? -div_quo[15:0] : div_quo[15:0]);
  assign slot_free   = !out_valid || pop;
  assign empty       = !out_valid;

  tbah_div #(
    .N(33),
    .D(17)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  ({mag, 1'b0} + 33'(sample_count)),
    .divisor   ({sample_count, 1'b0}),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    rd_data <= mem[head];
    if (state == tbah_pkg::B_CLOSE) begin
      mem[head] <= avg;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      tbah_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = tbah_pkg::B_EVAL;
        end
      end
      tbah_pkg::B_EVAL: begin
        if (!close) begin
          state_next = tbah_pkg::B_ADD;
        end else if (sample_count == '0) begin
          state_next = tbah_pkg::B_CLOSE;
        end else begin
          div_start  = 1'b1;
          state_next = tbah_pkg::B_DIV;
        end
      end
      tbah_pkg::B_DIV: begin
        if (div_done && (div_rem == div_rem)) begin
          state_next = tbah_pkg::B_CLOSE;
        end
      end
      tbah_pkg::B_CLOSE: begin
        state_next = tbah_pkg::B_ADD;
      end
      tbah_pkg::B_ADD: begin
        if (slot_free) begin
          state_next = tbah_pkg::B_IDLE;
        end
      end
      default: state_next = tbah_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tbah_pkg::B_IDLE;
      head         <= '0;
      fill         <= '0;
      bucket_start <= '0;
      sample_sum   <= '0;
      sample_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tbah_pkg::B_CLOSE) begin
        head         <= (head == HW'(HISTORY_DEPTH - 1)) ? '0 : head + 1'b1;
        fill         <= (fill == FW'(HISTORY_DEPTH)) ? fill : fill + 1'b1;
        bucket_start <= w_start;
        sample_sum   <= '0;
        sample_count <= '0;
      end
      if (state == tbah_pkg::B_ADD && slot_free) begin
        sample_count <= count_after;
        if (sample_count < 16'(MAX_COUNT)) begin
          sample_sum <= sample_sum + 32'(w_sample);
        end
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_start  <= q_word.start;
      w_sample <= q_word.sample;
    end
    if (state == tbah_pkg::B_EVAL) begin
      closed_r <= close;
      neg      <= sample_sum[31];
      avg_r    <= '0;
      evict_r  <= '0;
    end
    if (state == tbah_pkg::B_CLOSE) begin
      avg_r   <= avg;
      evict_r <= (fill == FW'(HISTORY_DEPTH)) ? rd_data : 16'sd0;
    end
    if (state == tbah_pkg::B_ADD && slot_free) begin
      bucket_closed  <= closed_r;
      closed_average <= avg_r;
      evicted_value  <= evict_r;
      bucket_count   <= count_after;
    end
  end

endmodule

### hw/rtl/time_bucket_average_history_unit.sv
// ----------------------------------------------------------------------------
// Time bucket average history unit
// Floors each sample time to a bucket, closes buckets into a history ring of
// rounded means, and reports one result word per input word.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake         Payload
// config    in         cfg_write         cfg_data (bucket length, seconds)
// input     in         push / full       time_seconds, sample_value
// result    out        pop / empty       bucket_closed, closed_average,
//                                        evicted_value, bucket_count
//
// The front end floors each time with its 32-step modulo divider; a word that
// closes a non-empty bucket also goes through the back end's 33-step mean
// divider, and any other word skips it. A two-entry queue separates the two,
// and a result register lets new words enter while a result waits. Reset is
// ready at once: the history ring tracks its fill count, so there is no
// clearing pass.
// ----------------------------------------------------------------------------
module time_bucket_average_history_unit #(
  parameter int HISTORY_DEPTH = 64,
  parameter int MAX_COUNT     = 65535
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        time_seconds,
  input  logic signed [15:0] sample_value,
  input  logic               pop,
  output logic               empty,
  output logic               bucket_closed,
  output logic signed [15:0] closed_average,
  output logic signed [15:0] evicted_value,
  output logic [15:0]        bucket_count
);

  logic            f_push;
  tbah_pkg::word_t f_word;
  logic            q_full;
  logic            q_pop;
  tbah_pkg::word_t q_word;
  logic            q_empty;

  tbah_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .time_seconds (time_seconds),
    .sample_value (sample_value),
    .q_push       (f_push),
    .q_word       (f_word),
    .q_full       (q_full)
  );

  tbah_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .word_in  (f_word),
    .full     (q_full),
    .pop      (q_pop),
    .word_out (q_word),
    .empty    (q_empty)
  );

  tbah_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_COUNT     (MAX_COUNT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_word         (q_word),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .bucket_closed  (bucket_closed),
    .closed_average (closed_average),
    .evicted_value  (evicted_value),
    .bucket_count   (bucket_count)
  );

endmodule

### dv/tb_time_bucket_average_history_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time bucket average history unit testbench
// Drives time/sample words through the push/full queue and checks each
// result word against a cycle-free predictor of the bucket, mean and history
// logic. A directed table covers the extremes and the special cases. Random
// phases follow, each with a new bucket length and runs of words inside one
// bucket. Both sides idle at random, and the result side holds off once for
// a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb_time_bucket_average_history_unit;

  localparam int HIST_DEPTH = 64;
  localparam int CNT_LIMIT  = 65535;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic               closed;
    logic signed [15:0] avg;
    logic signed [15:0] evicted;
    logic [15:0]        count;
  } bucket_result_t;

  typedef struct {
    logic [31:0]        t;
    logic signed [15:0] s;
    bit                 typed;
    bucket_result_t     res;
  } table_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [31:0]        cfg_data;
  logic               push;
  logic               full;
  logic [31:0]        time_seconds;
  logic signed [15:0] sample_value;
  logic               pop;
  logic               empty;
  logic               bucket_closed;
  logic signed [15:0] closed_average;
  logic signed [15:0] evicted_value;
  logic [15:0]        bucket_count;

  time_bucket_average_history_unit #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .MAX_COUNT    (CNT_LIMIT)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .time_seconds  (time_seconds),
    .sample_value  (sample_value),
    .pop           (pop),
    .empty         (empty),
    .bucket_closed (bucket_closed),
    .closed_average(closed_average),
    .evicted_value (evicted_value),
    .bucket_count  (bucket_count)
  );

  logic [31:0]        bucket_len;
  logic signed [15:0] avg_history [HIST_DEPTH];
  logic [31:0]        cur_start;
  logic signed [31:0] cur_sum;
  logic [15:0]        cur_count;

  bucket_result_t pending_results[$];
  table_row_t     directed_rows[$];
  int             errors;
  bit             idle_en;
  int             hold_req;
  int             hold_done;
  int             hold_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[time_bucket_average_history_unit] ERROR");
    $finish;
  end

  function automatic bit take_gap();
    return idle_en && ($urandom_range(0, 99) < 32);
  endfunction

  function automatic logic signed [15:0] bucket_mean(input logic signed [31:0] sum,
                                                     input logic [15:0] cnt);
    logic signed [63:0] wide;
    logic [63:0]        mag;
    logic [63:0]        q;
    if (cnt == 16'd0) return 16'sd0;
    wide = sum;
    mag  = (wide < 0) ? -wide : wide;
    q    = (2 * mag + 64'(cnt)) / (2 * 64'(cnt));
    return (sum < 0) ? -q[15:0] : q[15:0];
  endfunction

  task automatic close_and_accumulate(input logic [31:0] t, input logic signed [15:0] s,
                                      output bucket_result_t r);
    logic [31:0] len;
    logic [31:0] st;
    len = (bucket_len == 32'd0) ? 32'd1 : bucket_len;
    st  = t - (t % len);
    r   = '0;
    if (cur_start == 32'd0 || cur_start != st) begin
      r.closed  = 1'b1;
      r.evicted = avg_history[0];
      for (int i = 0; i < HIST_DEPTH - 1; i++) avg_history[i] = avg_history[i + 1];
      r.avg = bucket_mean(cur_sum, cur_count);
      avg_history[HIST_DEPTH - 1] = r.avg;
      cur_sum   = 0;
      cur_count = 16'd0;
      cur_start = st;
    end
    if (cur_count < CNT_LIMIT) begin
      cur_sum   = cur_sum + s;
      cur_count = cur_count + 16'd1;
    end
    r.count = cur_count;
  endtask

  task automatic send_word(input logic [31:0] t, input logic signed [15:0] s,
                           input bit typed, input bucket_result_t typed_res);
    bucket_result_t r;
    @(negedge clk);
    while (take_gap()) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    time_seconds <= t;
    sample_value <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    close_and_accumulate(t, s, r);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic set_bucket_len(input logic [31:0] v);
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (45) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    bucket_len = v;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic run_phase(input logic [31:0] len_cfg, input int n_words, input int hold_at);
    logic [31:0] len;
    logic [31:0] t0;
    logic [31:0] st;
    logic [31:0] span;
    int          run_len;
    int          sent;
    set_bucket_len(len_cfg);
    len  = (len_cfg == 32'd0) ? 32'd1 : len_cfg;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 99) < 15) begin
        run_len = 1;
        st      = 32'd0;
        span    = 32'hffff_ffff;
      end else begin
        run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 6);
        case ($urandom_range(0, 19))
          0, 1:    t0 = $urandom_range(0, len - 1);
          2:       t0 = 32'hffff_ffff;
          default: t0 = $urandom();
        endcase
        st   = t0 - (t0 % len);
        span = len - 1;
        if (32'hffff_ffff - st < span) span = ~st;
      end
      for (int k = 0; k < run_len && sent < n_words; k++) begin
        if (sent == hold_at) hold_req++;
        send_word(st + $urandom_range(0, span), pick_sample(), 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic add_row(input logic [31:0] t, input logic signed [15:0] s, input bit typed,
                         input logic c, input logic signed [15:0] a,
                         input logic signed [15:0] e, input logic [15:0] n);
    table_row_t row;
    row.t   = t;
    row.s   = s;
    row.typed = typed;
    row.res = '{closed: c, avg: a, evicted: e, count: n};
    directed_rows.push_back(row);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_data     = 32'd0;
    push         = 1'b0;
    time_seconds = 32'd0;
    sample_value = 16'sd0;
    pop          = 1'b0;
    errors       = 0;
    idle_en      = 1'b1;
    hold_req     = 0;
    bucket_len   = tbah_pkg::BUCKET_SECONDS_RESET;
    cur_start    = 32'd0;
    cur_sum      = 0;
    cur_count    = 16'd0;
    for (int i = 0; i < HIST_DEPTH; i++) avg_history[i] = 16'sd0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_row(32'd0,          16'sd100,    1, 1'b1, 16'sd0,      16'sd0, 16'd1);
    add_row(32'd5,          16'sh8000,   1, 1'b1, 16'sd100,    16'sd0, 16'd1);
    add_row(32'd21600,      16'sh7fff,   1, 1'b1, 16'sh8000,   16'sd0, 16'd1);
    add_row(32'd21601,      16'sh7fff,   1, 1'b0, 16'sd0,      16'sd0, 16'd2);
    add_row(32'd43199,      -16'sd1,     1, 1'b0, 16'sd0,      16'sd0, 16'd3);
    add_row(32'd43200,      16'sd0,      0, 1'b0, 16'sd0,      16'sd0, 16'd0);
    add_row(32'd100000,     -16'sd1,     0, 1'b0, 16'sd0,      16'sd0, 16'd0);
    add_row(32'd100001,     -16'sd2,     0, 1'b0, 16'sd0,      16'sd0, 16'd0);
    add_row(32'd200000,     16'sd1,      0, 1'b0, 16'sd0,      16'sd0, 16'd0);
    add_row(32'd200001,     16'sd2,      0, 1'b0, 16'sd0,      16'sd0, 16'd0);
    add_row(32'd300000,     16'sd5,      0, 1'b0, 16'sd0,      16'sd0, 16'd0);
    add_row(32'hffff_ffff,  16'sh8000,   0, 1'b0, 16'sd0,      16'sd0, 16'd0);
    add_row(32'hffff_ffff,  16'sh8000,   0, 1'b0, 16'sd0,      16'sd0, 16'd0);
    add_row(32'hffff_ffff,  16'sh8001,   0, 1'b0, 16'sd0,      16'sd0, 16'd0);
    add_row(32'hffff_fffe,  16'sh7fff,   0, 1'b0, 16'sd0,      16'sd0, 16'd0);
    add_row(32'd12345,      16'sd7,      0, 1'b0, 16'sd0,      16'sd0, 16'd0);
    add_row(32'd12346,      16'sd8,      0, 1'b0, 16'sd0,      16'sd0, 16'd0);
    foreach (directed_rows[i])
      send_word(directed_rows[i].t, directed_rows[i].s, directed_rows[i].typed,
                directed_rows[i].res);

    run_phase(32'd1, 90, -1);
    run_phase(32'hffff_ffff, 80, -1);
    idle_en = 1'b0;
    run_phase(32'd0, 60, -1);
    idle_en = 1'b1;
    run_phase($urandom_range(2, 5000), 100, 40);
    run_phase(tbah_pkg::BUCKET_SECONDS_RESET, 100, -1);

    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[time_bucket_average_history_unit] OK");
    else
      $display("[time_bucket_average_history_unit] ERROR");
    $finish;
  end

  initial begin
    hold_done = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !take_gap();
      end
    end
  end

  always @(posedge clk) begin
    bucket_result_t got;
    bucket_result_t want;
    if (!rst && pop && !empty) begin
      got = '{closed: bucket_closed, avg: closed_average, evicted: evicted_value,
              count: bucket_count};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word closed=%0d avg=%0d evicted=%0d count=%0d",
                 $time, got.closed, got.avg, got.evicted, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          $display({"%0t: expected closed=%0d avg=%0d evicted=%0d count=%0d, ",
                    "got closed=%0d avg=%0d evicted=%0d count=%0d"},
                   $time, want.closed, want.avg, want.evicted, want.count,
                   got.closed, got.avg, got.evicted, got.count);
        end
      end
    end
  end

endmodule
